// ===== rtl/tocc_pkg.sv =====
`default_nettype none

package tocc_pkg;

    localparam int OUT_W = 32;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_APPLY   = 2'd1,
        CMD_QUIT    = 2'd2,
        CMD_INVALID = 2'd3
    } cmd_t;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;
    localparam logic [2:0] OP_MOD = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RESULT   = 3'd1;
    localparam logic [2:0] ST_TOO_MANY = 3'd2;
    localparam logic [2:0] ST_TOO_FEW  = 3'd3;
    localparam logic [2:0] ST_DIV_ZERO = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;
    localparam logic [2:0] ST_INVALID  = 3'd6;
    localparam logic [2:0] ST_QUIT     = 3'd7;

    localparam logic [1:0] MAX_OPERANDS = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_DIV,
        S_DONE
    } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/two_operand_checked_calculator_unit.sv =====
`default_nettype none
// Push, quit, invalid, add, subtract and every early error go straight to the output
// stage; multiply passes through the multiply and range check steps; divide and modulo
// by a nonzero value run the divider (one quotient bit per cycle); power repeats the
// multiply and range check until the exponent runs out or the product overflows.
// A new word is taken only once the last has moved into the output register; the output register frees
// the input while a result waits. Reset (async, active low) empties the operands and output.

module two_operand_checked_calculator_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] operand_value,
    input  wire logic [2:0]  operation,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [31:0]      result_value
);
    import tocc_pkg::*;

    localparam int DW = DATA_WIDTH;

    seq_state_t state_reg, state_next;

    logic [1:0]           cnt_reg, cnt_next;
    logic [DW-1:0]        opa_reg, opa_next;
    logic [DW-1:0]        opb_reg, opb_next;
    logic signed [DW-1:0] acc_reg, acc_next;
    logic signed [DW-1:0] base_reg, base_next;
    logic [DW-1:0]        exp_reg, exp_next;
    logic signed [2*DW-1:0] prod_reg, prod_next;
    logic [2:0]           op_reg, op_next;
    logic                 negq_reg, negq_next;
    logic                 negr_reg, negr_next;
    logic [2:0]           res_st_reg, res_st_next;
    logic [DW-1:0]        res_val_reg, res_val_next;
    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           out_st_reg, out_st_next;
    logic [31:0]          out_val_reg, out_val_next;

    logic          accept;
    logic          out_load;
    logic          go_mul;
    logic          go_div;
    logic          div_start;
    logic          div_done;
    logic [DW-1:0] div_q;
    logic [DW-1:0] div_r;
    logic [DW-1:0] mag_a;
    logic [DW-1:0] mag_b;
    logic [DW:0]   sum;
    logic          prod_ok;
    logic          a_zero, a_one, a_mone;
    logic          op_known;

    assign mag_a    = opa_reg[DW-1] ? (~opa_reg + DW'(1)) : opa_reg;
    assign mag_b    = opb_reg[DW-1] ? (~opb_reg + DW'(1)) : opb_reg;
    assign sum      = {opa_reg[DW-1], opa_reg} + {opb_reg[DW-1], opb_reg};
    assign prod_ok  = (prod_reg[2*DW-1:DW-1] == '0) || (prod_reg[2*DW-1:DW-1] == '1);
    assign a_zero   = (opa_reg == '0);
    assign a_one    = (opa_reg == DW'(1));
    assign a_mone   = (opa_reg == '1);
    assign op_known = (operation <= OP_MOD);

    tocc_div #(
        .DATA_WIDTH(DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_a),
        .divisor  (mag_b),
        .done     (div_done),
        .quotient (div_q),
        .remainder(div_r)
    );

    // handshake
    always_comb
    begin
        in_stall = (state_reg != S_IDLE);
        accept   = in_valid && (state_reg == S_IDLE);
        out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (go_mul)
                        state_next = S_MUL;
                    else if (go_div)
                        state_next = S_DIV;
                    else
                        state_next = S_DONE;
                end
            end
            S_MUL:
                state_next = S_CHK;
            S_CHK:
            begin
                if (!prod_ok || (exp_reg == '0))
                    state_next = S_DONE;
                else
                    state_next = S_MUL;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next     = cnt_reg;
        opa_next     = opa_reg;
        opb_next     = opb_reg;
        acc_next     = acc_reg;
        base_next    = base_reg;
        exp_next     = exp_reg;
        prod_next    = prod_reg;
        op_next      = op_reg;
        negq_next    = negq_reg;
        negr_next    = negr_reg;
        res_st_next  = res_st_reg;
        res_val_next = res_val_reg;
        go_mul       = 1'b0;
        go_div       = 1'b0;
        div_start    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_val_next = '0;
                    op_next      = operation;
                    cnt_next     = '0;
                    case (cmd_t'(command))
                        CMD_PUSH:
                        begin
                            if (cnt_reg >= MAX_OPERANDS)
                                res_st_next = ST_TOO_MANY;
                            else
                            begin
                                res_st_next = ST_OK;
                                cnt_next    = cnt_reg + 2'd1;
                                if (cnt_reg == '0)
                                    opa_next = operand_value[DW-1:0];
                                else
                                    opb_next = operand_value[DW-1:0];
                            end
                        end
                        CMD_APPLY:
                        begin
                            if (!op_known)
                                res_st_next = ST_INVALID;
                            else if (cnt_reg < MAX_OPERANDS)
                                res_st_next = ST_TOO_FEW;
                            else if (cnt_reg > MAX_OPERANDS)
                                res_st_next = ST_TOO_MANY;
                            else
                            begin
                                res_st_next = ST_RESULT;
                                case (operation)
                                    OP_ADD:
                                    begin
                                        if (sum[DW] != sum[DW-1])
                                            res_st_next = ST_OVERFLOW;
                                        else
                                            res_val_next = sum[DW-1:0];
                                    end
                                    OP_SUB:
                                        res_val_next = opa_reg - opb_reg;
                                    OP_MUL:
                                    begin
                                        go_mul    = 1'b1;
                                        acc_next  = opa_reg;
                                        base_next = opb_reg;
                                        exp_next  = DW'(1);
                                    end
                                    OP_POW:
                                    begin
                                        if (opb_reg[DW-1])
                                        begin
                                            if (a_one)
                                                res_val_next = DW'(1);
                                            else if (a_mone)
                                                res_val_next = opb_reg[0] ? '1 : DW'(1);
                                            else
                                                res_st_next = ST_OVERFLOW;
                                        end
                                        else if (a_zero)
                                            res_val_next = (opb_reg == '0) ? DW'(1) : '0;
                                        else if (a_one || (opb_reg == '0))
                                            res_val_next = DW'(1);
                                        else if (a_mone)
                                            res_val_next = opb_reg[0] ? '1 : DW'(1);
                                        else
                                        begin
                                            go_mul    = 1'b1;
                                            acc_next  = DW'(1);
                                            base_next = opa_reg;
                                            exp_next  = opb_reg;
                                        end
                                    end
                                    default:
                                    begin
                                        // divide and modulo
                                        if (opb_reg == '0)
                                            res_st_next = ST_DIV_ZERO;
                                        else
                                        begin
                                            go_div    = 1'b1;
                                            div_start = 1'b1;
                                            negq_next = opa_reg[DW-1] ^ opb_reg[DW-1];
                                            negr_next = opa_reg[DW-1];
                                        end
                                    end
                                endcase
                            end
                        end
                        CMD_QUIT:
                            res_st_next = ST_QUIT;
                        default:
                            res_st_next = ST_INVALID;
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next = (2*DW)'(acc_reg) * (2*DW)'(base_reg);
                exp_next  = exp_reg - DW'(1);
            end
            S_CHK:
            begin
                if (!prod_ok)
                    res_st_next = ST_OVERFLOW;
                else
                begin
                    acc_next     = prod_reg[DW-1:0];
                    res_val_next = prod_reg[DW-1:0];
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (op_reg == OP_DIV)
                    begin
                        if (!negq_reg && div_q[DW-1])
                            res_st_next = ST_OVERFLOW;
                        else
                            res_val_next = negq_reg ? (~div_q + DW'(1)) : div_q;
                    end
                    else
                        res_val_next = negr_reg ? (~div_r + DW'(1)) : div_r;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_st_next    = out_st_reg;
        out_val_next   = out_val_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_st_next    = res_st_reg;
            out_val_next   = (res_st_reg == ST_RESULT) ? OUT_W'($signed(res_val_reg)) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        acc_reg     <= acc_next;
        base_reg    <= base_next;
        exp_reg     <= exp_next;
        prod_reg    <= prod_next;
        op_reg      <= op_next;
        negq_reg    <= negq_next;
        negr_reg    <= negr_next;
        res_st_reg  <= res_st_next;
        res_val_reg <= res_val_next;
        out_st_reg  <= out_st_next;
        out_val_reg <= out_val_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_st_reg;
    assign result_value = out_val_reg;

endmodule

`default_nettype wire

// ===== rtl/tocc_div.sv =====
`default_nettype none

module tocc_div #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      quotient,
    output logic [DATA_WIDTH-1:0]      remainder
);
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] dsr_reg, dsr_next;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;

    // one restoring step per cycle
    assign shifted = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = ~diff[DATA_WIDTH];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DATA_WIDTH);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DATA_WIDTH-2:0], ge};
            rem_next = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/tocc_checker.sv =====
`default_nettype none

module tocc_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [1:0]  command,
    input wire logic [31:0] operand_value,
    input wire logic [2:0]  operation,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  status,
    input wire logic [31:0] result_value
);
    import tocc_pkg::*;

    logic unused_ok;
    assign unused_ok = ^{command, operand_value, operation};

    // a word taken blocks the input on the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accepting a word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output word dropped while stalled");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_RESULT)) |-> (result_value == '0))
        else $error("nonzero value with non-result status");

    a_sign_ext: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((result_value[31:DATA_WIDTH-1] == '0) ||
                       (result_value[31:DATA_WIDTH-1] == '1)))
        else $error("result value not sign extended");

endmodule

bind two_operand_checked_calculator_unit tocc_checker #(
    .DATA_WIDTH(DATA_WIDTH)
) u_tocc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .operand_value(operand_value),
    .operation    (operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .result_value (result_value)
);

`default_nettype wire

// ===== sim/two_operand_checked_calculator_unit_test.sv =====
module two_operand_checked_calculator_unit_test;

    import tocc_pkg::*;

    localparam logic [2:0] OP_UNDEF_LO = 3'd6;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] MINUS_ONE = 32'hffff_ffff;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] val;
    } calc_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = CMD_PUSH;
    logic [31:0] operand_value = '0;
    logic [2:0]  operation = OP_ADD;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] result_value;

    calc_word_t  pending_words[$];
    int          mismatches = 0;
    int          hold_req = 0;
    int          hold_left = 0;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;

    // operand store of the predictor
    logic [1:0]  held_count = '0;
    logic [31:0] held_a = '0;
    logic [31:0] held_b = '0;

    two_operand_checked_calculator_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .operand_value(operand_value),
        .operation(operation),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .result_value(result_value)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #4_800_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch: %s", msg);
    endtask

    function automatic void drop_operands();
        held_count = '0;
        held_a = '0;
        held_b = '0;
    endfunction

    function automatic logic [2:0] keep_if_fits(input longint v, output longint r);
        r = v;
        return (longint'(int'(v)) == v) ? ST_RESULT : ST_OVERFLOW;
    endfunction

    function automatic logic [2:0] raise_checked(input longint base, input longint ex,
                                                 output longint r);
        longint acc;
        acc = 1;
        r = 0;
        if (ex < 0) begin
            if (base == 1) begin
                r = 1;
                return ST_RESULT;
            end
            if (base == -1) begin
                r = ex[0] ? -1 : 1;
                return ST_RESULT;
            end
            return ST_OVERFLOW;
        end
        if (base == 0) begin
            r = (ex == 0) ? 1 : 0;
            return ST_RESULT;
        end
        if (base == 1 || base == -1) begin
            r = (base == -1 && ex[0]) ? -1 : 1;
            return ST_RESULT;
        end
        while (ex > 0) begin
            acc = acc * base;
            if (longint'(int'(acc)) != acc)
                return ST_OVERFLOW;
            ex--;
        end
        r = acc;
        return ST_RESULT;
    endfunction

    function automatic calc_word_t calc_predict(input cmd_t c, input logic [31:0] v,
                                                input logic [2:0] op);
        calc_word_t w;
        longint a, b, r;
        logic [2:0] st;
        st = ST_OK;
        r = 0;
        a = longint'($signed(held_a));
        b = longint'($signed(held_b));
        case (c)
            CMD_PUSH:
                if (held_count >= MAX_OPERANDS) begin
                    st = ST_TOO_MANY;
                    drop_operands();
                end else begin
                    if (held_count == 0)
                        held_a = v;
                    else
                        held_b = v;
                    held_count++;
                end
            CMD_APPLY: begin
                if (op > OP_MOD)
                    st = ST_INVALID;
                else if (held_count < MAX_OPERANDS)
                    st = ST_TOO_FEW;
                else begin
                    case (op)
                        OP_ADD: st = keep_if_fits(a + b, r);
                        OP_SUB: begin
                            r = longint'($signed(held_a - held_b));
                            st = ST_RESULT;
                        end
                        OP_MUL: st = keep_if_fits(a * b, r);
                        OP_DIV: st = (b == 0) ? ST_DIV_ZERO : keep_if_fits(a / b, r);
                        OP_POW: st = raise_checked(a, b, r);
                        default:
                            if (b == 0)
                                st = ST_DIV_ZERO;
                            else begin
                                r = a % b;
                                st = ST_RESULT;
                            end
                    endcase
                end
                drop_operands();
            end
            CMD_QUIT: begin
                st = ST_QUIT;
                drop_operands();
            end
            default: begin
                st = ST_INVALID;
                drop_operands();
            end
        endcase
        w.st = st;
        w.val = (st == ST_RESULT) ? r[31:0] : '0;
        return w;
    endfunction

    // result side: compare, then decide next cycle's stall
    always @(posedge clk)
    begin
        calc_word_t want;
        if (out_valid === 1'b1 && out_stall === 1'b0) begin
            if (pending_words.size() == 0)
                report_mismatch($sformatf("unexpected word status %0d value %0d",
                                          status, $signed(result_value)));
            else begin
                want = pending_words.pop_front();
                if (status !== want.st)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
                if (result_value !== want.val)
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              $signed(result_value), $signed(want.val)));
            end
        end
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else
            out_stall <= !rx_quiet && ($urandom_range(0, 99) < 7);
    end

    task automatic send_word(input cmd_t c, input logic [31:0] v, input logic [2:0] op);
        in_valid <= 1'b1;
        command <= c;
        operand_value <= v;
        operation <= op;
        do @(posedge clk); while (in_stall !== 1'b0);
        pending_words = {pending_words, calc_predict(c, v, op)};
        if (!tx_quiet && $urandom_range(0, 99) < 7) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic apply_pair(input logic [31:0] a, input logic [31:0] b,
                              input logic [2:0] op);
        send_word(CMD_PUSH, a, 3'($urandom_range(0, 7)));
        send_word(CMD_PUSH, b, 3'($urandom_range(0, 7)));
        send_word(CMD_APPLY, $urandom, op);
    endtask

    task automatic wait_drained();
        if (pending_words.size() != 0) begin
            in_valid <= 1'b0;
            while (pending_words.size() != 0) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] pick_operand();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 4))
            0:
                case ($urandom_range(0, 5))
                    0: r = INT_MIN;
                    1: r = INT_MAX;
                    2: r = '0;
                    3: r = 32'd1;
                    4: r = MINUS_ONE;
                    default: r = INT_MIN + 32'd1;
                endcase
            1: r = 32'($urandom_range(0, 40)) - 32'd20;
            2: r = {{16{r[15]}}, r[15:0]};
            3: r = {{20{r[11]}}, r[11:0]};
            default: ;
        endcase
        return r;
    endfunction

    task automatic test_operand_store();
        send_word(CMD_PUSH, INT_MAX, OP_ADD);
        send_word(CMD_PUSH, INT_MIN, OP_UNDEF_HI);
        send_word(CMD_PUSH, 32'd3, OP_MOD);
        send_word(CMD_APPLY, '0, OP_UNDEF_LO);
    endtask

    task automatic test_arithmetic();
        apply_pair(INT_MAX, 32'd1, OP_ADD);
        apply_pair(INT_MIN, INT_MAX, OP_SUB);
        apply_pair(32'h0001_0000, 32'h0001_0000, OP_MUL);
    endtask

    task automatic test_division();
        apply_pair(INT_MIN, MINUS_ONE, OP_DIV);
        apply_pair(INT_MIN, MINUS_ONE, OP_MOD);
        apply_pair(32'd7, '0, OP_MOD);
    endtask

    task automatic test_power();
        apply_pair('0, '0, OP_POW);
        apply_pair(MINUS_ONE, -32'sd3, OP_POW);
        apply_pair(32'd2, MINUS_ONE, OP_POW);
    endtask

    task automatic test_flush_commands();
        send_word(CMD_PUSH, 32'd1, OP_ADD);
        send_word(CMD_APPLY, '1, OP_ADD);
        send_word(CMD_QUIT, '1, OP_UNDEF_HI);
        send_word(CMD_INVALID, '0, OP_POW);
    endtask

    // output held off long enough that the block backs up into its input
    task automatic test_backpressure();
        hold_req = 200;
        repeat (6) apply_pair(pick_operand(), pick_operand(), 3'($urandom_range(0, 5)));
        wait_drained();
    endtask

    task automatic test_drain_pause();
        apply_pair(pick_operand(), pick_operand(), OP_MUL);
        send_word(CMD_PUSH, pick_operand(), OP_ADD);
        wait_drained();
        send_word(CMD_PUSH, pick_operand(), OP_ADD);
        send_word(CMD_APPLY, '0, OP_DIV);
    endtask

    task automatic test_random_traffic(input int count);
        int sent;
        logic [2:0] op;
        logic [31:0] a, b;
        sent = 0;
        while (sent < count) begin
            tx_quiet = (sent >= 600 && sent < 900);
            rx_quiet = tx_quiet;
            if ($urandom_range(0, 99) < 80) begin
                if ($urandom_range(0, 99) < 5)
                    op = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
                else
                    op = 3'($urandom_range(OP_ADD, OP_MOD));
                a = pick_operand();
                if (op == OP_POW && $urandom_range(0, 9) != 0)
                    b = 32'($urandom_range(0, 34)) - 32'd2;
                else
                    b = pick_operand();
                apply_pair(a, b, op);
                sent += 3;
            end else begin
                send_word(cmd_t'($urandom_range(0, 3)), pick_operand(),
                          3'($urandom_range(0, 7)));
                sent++;
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_operand_store();
        test_arithmetic();
        test_division();
        test_power();
        test_flush_commands();
        wait_drained();
        test_backpressure();
        test_drain_pause();
        test_random_traffic(1800);
        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
